### rtl/core/page_bitmap_allocator_core_macros.svh
// Assertion macros for the page bitmap allocator.
// Each macro expects signals named clk and rst in the module that uses it.
`ifndef PAGE_BITMAP_ALLOCATOR_CORE_MACROS_SVH
`define PAGE_BITMAP_ALLOCATOR_CORE_MACROS_SVH
`ifndef SYNTH
// General property, checked at every rising edge outside reset.
`define PBA_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Same-cycle implication.
`define PBA_ASSERT_IMPL(name, ante, cons, msg) \
  `PBA_ASSERT(name, (ante) |-> (cons), msg)
`else
`define PBA_ASSERT(name, prop, msg)
`define PBA_ASSERT_IMPL(name, ante, cons, msg)
`endif
`endif

### rtl/core/pba_pkg.sv
package pba_pkg;

  // Operation codes.
  localparam logic [1:0] FUNC_SET   = 2'd0;
  localparam logic [1:0] FUNC_ALLOC = 2'd1;
  localparam logic [1:0] FUNC_FREE  = 2'd2;

  // Result status codes.
  localparam logic [2:0] STAT_OK          = 3'd0;
  localparam logic [2:0] STAT_ZERO        = 3'd1;
  localparam logic [2:0] STAT_MULTI       = 3'd2;
  localparam logic [2:0] STAT_NONE        = 3'd3;
  localparam logic [2:0] STAT_DOUBLE_FREE = 3'd4;
  localparam logic [2:0] STAT_RANGE       = 3'd5;

  // Page count register.
  localparam int             CNT_W     = 13;
  localparam logic [CNT_W-1:0] CNT_RESET = 13'd4096;

  typedef struct packed {
    logic [1:0]  func;
    logic [11:0] page_index;
    logic        mark_used;
    logic [11:0] pages_wanted;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [11:0] result_index;
  } rsp_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_ADDR,
    S_MODIFY,
    S_SCAN
  } state_t;

endpackage

### rtl/core/page_bitmap_allocator_core.sv
// Channel   Ports                         Handshake
// --------  ----------------------------  ---------------------------------------
// request   start, busy, request          taken when start is high and busy low
// result    done, result                  valid for the one cycle done is high
// config    cfg_valid, cfg_ready, cfg_data written when cfg_valid and cfg_ready
//
// Set and free: an in-range request passes the decode, address and modify states; done is
// registered from the last of them and busy is high until done rises. Allocate: the scan
// reads one bitmap word per cycle through the single read port (any WORD_BITS works).
// After reset a clearing pass writes all ones to the ceil(PAGES / WORD_BITS) bitmap words,
// one per cycle; busy stays high meanwhile, configuration writes are still taken.
// Results cannot be stalled; a new request is taken in the cycle its predecessor's result shows.
`include "page_bitmap_allocator_core_macros.svh"

module page_bitmap_allocator_core #(
  parameter int PAGES     = 4096,
  parameter int WORD_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  pba_pkg::req_t                 request,
  output logic                          done,
  output pba_pkg::rsp_t                 result,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [pba_pkg::CNT_W-1:0]     cfg_data
);

  localparam int NWORDS = (PAGES + WORD_BITS - 1) / WORD_BITS;
  localparam int AW     = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int BW     = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
  localparam int LIM_W  = ($clog2(PAGES + 1) > pba_pkg::CNT_W) ?
                          $clog2(PAGES + 1) : pba_pkg::CNT_W;
  localparam int CW     = LIM_W + 1;
  // Exact division of a 12-bit index by WORD_BITS through a reciprocal.
  localparam int DIV_S  = 12 + $clog2(WORD_BITS);
  localparam int DIV_M  = ((2 ** DIV_S) + WORD_BITS - 1) / WORD_BITS;
  localparam int PW     = 12 + DIV_S + 1;

  pba_pkg::state_t state, state_next;
  pba_pkg::req_t   req_q;

  logic [pba_pkg::CNT_W-1:0] pages_in_use;
  logic [CW-1:0]             lim;
  logic [11:0]               word_q;
  logic [BW-1:0]             bit_q;
  logic [AW-1:0]             clr_addr;
  logic [AW-1:0]             issue_addr;
  logic [CW-1:0]             issue_base;
  logic                      pend_v;
  logic [AW-1:0]             pend_addr;
  logic [CW-1:0]             pend_base;

  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic [WORD_BITS-1:0] wr_data;
  logic                 rd_en;
  logic [AW-1:0]        rd_addr;
  logic [WORD_BITS-1:0] rd_data;

  logic [PW-1:0]        quot_prod;
  logic [11:0]          word_calc;
  logic [11:0]          rem_calc;
  logic [WORD_BITS-1:0] bit_mask;
  logic                 zero_found;
  logic [BW-1:0]        zero_pos;
  logic [WORD_BITS-1:0] zero_mask;
  logic                 issue_ok;
  logic                 hit;
  logic                 scan_issue;
  logic                 fin;
  logic [2:0]           fin_status;
  logic [11:0]          fin_index;

  // Bitmap storage.
  pba_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (NWORDS)
  ) u_bitmap (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Effective page count, capped at the bitmap size.
  assign lim = (CW'(pages_in_use) > CW'(PAGES)) ? CW'(PAGES) : CW'(pages_in_use);

  assign busy      = (state != pba_pkg::S_IDLE);
  assign cfg_ready = 1'b1;

  // Word number and bit position of the requested page.
  assign quot_prod = PW'(req_q.page_index) * PW'(DIV_M);
  assign word_calc = 12'(quot_prod >> DIV_S);
  assign rem_calc  = req_q.page_index - 12'(word_q * 24'(WORD_BITS));
  assign bit_mask  = WORD_BITS'(1) << bit_q;

  // Lowest free page in the word under examination.
  always_comb begin
    zero_pos = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!rd_data[i]) begin
        zero_pos = BW'(i);
      end
    end
  end
  assign zero_found = ~&rd_data;
  assign zero_mask  = WORD_BITS'(1) << zero_pos;

  // Scan control.
  assign issue_ok = (issue_base < lim);
  assign hit      = pend_v && zero_found && ((pend_base + CW'(zero_pos)) < lim);

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      pba_pkg::S_CLEAR: begin
        if (clr_addr == AW'(NWORDS - 1)) begin
          state_next = pba_pkg::S_IDLE;
        end
      end
      pba_pkg::S_IDLE: begin
        if (start) begin
          state_next = pba_pkg::S_DECODE;
        end
      end
      pba_pkg::S_DECODE: begin
        priority if ((req_q.func == pba_pkg::FUNC_SET || req_q.func == pba_pkg::FUNC_FREE)
                     && (CW'(req_q.page_index) < lim)) begin
          state_next = pba_pkg::S_ADDR;
        end else if (req_q.func == pba_pkg::FUNC_ALLOC && req_q.pages_wanted == 12'd1) begin
          state_next = pba_pkg::S_SCAN;
        end else begin
          state_next = pba_pkg::S_IDLE;
        end
      end
      pba_pkg::S_ADDR: begin
        state_next = pba_pkg::S_MODIFY;
      end
      pba_pkg::S_MODIFY: begin
        state_next = pba_pkg::S_IDLE;
      end
      pba_pkg::S_SCAN: begin
        if (hit || !issue_ok) begin
          state_next = pba_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = pba_pkg::S_IDLE;
      end
    endcase
  end

  // Memory accesses and completion.
  always_comb begin
    wr_en      = 1'b0;
    wr_addr    = AW'(word_q);
    wr_data    = rd_data;
    rd_en      = 1'b0;
    rd_addr    = AW'(word_q);
    scan_issue = 1'b0;
    fin        = 1'b0;
    fin_status = pba_pkg::STAT_OK;
    fin_index  = req_q.page_index;
    unique case (state)
      pba_pkg::S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_addr;
        wr_data = '1;
      end
      pba_pkg::S_DECODE: begin
        priority if (req_q.func == pba_pkg::FUNC_SET || req_q.func == pba_pkg::FUNC_FREE) begin
          if (CW'(req_q.page_index) >= lim) begin
            fin        = 1'b1;
            fin_status = pba_pkg::STAT_RANGE;
          end
        end else if (req_q.func == pba_pkg::FUNC_ALLOC) begin
          if (req_q.pages_wanted == 12'd0) begin
            fin        = 1'b1;
            fin_status = pba_pkg::STAT_ZERO;
          end else if (req_q.pages_wanted != 12'd1) begin
            fin        = 1'b1;
            fin_status = pba_pkg::STAT_MULTI;
          end
        end else begin
          // Undefined operation: echo the index with a good status.
          fin = 1'b1;
        end
      end
      pba_pkg::S_ADDR: begin
        rd_en = 1'b1;
      end
      pba_pkg::S_MODIFY: begin
        fin = 1'b1;
        if (req_q.func == pba_pkg::FUNC_SET) begin
          wr_en   = 1'b1;
          wr_data = req_q.mark_used ? (rd_data | bit_mask) : (rd_data & ~bit_mask);
        end else if (!rd_data[bit_q]) begin
          fin_status = pba_pkg::STAT_DOUBLE_FREE;
        end else begin
          wr_en   = 1'b1;
          wr_data = rd_data & ~bit_mask;
        end
      end
      pba_pkg::S_SCAN: begin
        if (hit) begin
          fin       = 1'b1;
          fin_index = 12'(pend_base + CW'(zero_pos));
          wr_en     = 1'b1;
          wr_addr   = pend_addr;
          wr_data   = rd_data | zero_mask;
        end else if (!issue_ok) begin
          fin        = 1'b1;
          fin_status = pba_pkg::STAT_NONE;
        end else begin
          scan_issue = 1'b1;
          rd_en      = 1'b1;
          rd_addr    = issue_addr;
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= pba_pkg::S_CLEAR;
      clr_addr     <= '0;
      pend_v       <= 1'b0;
      done         <= 1'b0;
      pages_in_use <= pba_pkg::CNT_RESET;
    end else begin
      state <= state_next;
      done  <= fin;
      if (state == pba_pkg::S_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
      end
      if (cfg_valid) begin
        pages_in_use <= cfg_data;
      end
      if (state == pba_pkg::S_DECODE) begin
        pend_v <= 1'b0;
      end else if (scan_issue) begin
        pend_v <= 1'b1;
      end
    end
  end

  // Request, address and scan datapath registers.
  always_ff @(posedge clk) begin
    if (state == pba_pkg::S_IDLE && start) begin
      req_q <= request;
    end
    if (state == pba_pkg::S_DECODE) begin
      word_q     <= word_calc;
      issue_addr <= '0;
      issue_base <= '0;
    end
    if (state == pba_pkg::S_ADDR) begin
      bit_q <= BW'(rem_calc);
    end
    if (scan_issue) begin
      issue_addr <= issue_addr + AW'(1);
      issue_base <= issue_base + CW'(WORD_BITS);
      pend_addr  <= issue_addr;
      pend_base  <= issue_base;
    end
    if (fin) begin
      result.status       <= fin_status;
      result.result_index <= fin_index;
    end
  end

  `PBA_ASSERT_IMPL(a_done_idle, done, !busy, "result strobe while a request is in work")
  `PBA_ASSERT(a_accept_busy, (start && !busy) |=> busy, "accepted request did not raise busy")
  `PBA_ASSERT_IMPL(a_no_write_idle, state == pba_pkg::S_IDLE, !wr_en, "bitmap write while idle")
  `PBA_ASSERT_IMPL(a_scan_write, wr_en && state == pba_pkg::S_SCAN, pend_v, "claim without word")

endmodule

### rtl/core/pba_ram.sv
module pba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                                     clk,
  input  logic                                     wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                         wr_data,
  input  logic                                     rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### test/page_bitmap_allocator_core_tb.sv
module page_bitmap_allocator_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pba_pkg::*;

  localparam int NUM_PAGES = 4096;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int MAX_SHOWN = 10;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  req_t request = '0;
  logic done;
  rsp_t result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CNT_W-1:0] cfg_data = '0;

  // Shadow copy of the page map and the page count register.
  bit used_pages [NUM_PAGES];
  int unsigned page_count;
  rsp_t awaited_results [$];
  int unsigned mismatch_count = 0;
  int unsigned idle_pct = 0;

  page_bitmap_allocator_core #(
    .PAGES(NUM_PAGES),
    .WORD_BITS(32)
  ) dut (
    .clk,
    .rst,
    .start,
    .busy,
    .request,
    .done,
    .result,
    .cfg_valid,
    .cfg_ready,
    .cfg_data
  );

  always #1 clk = ~clk;

  // Counts above the bitmap size manage the whole bitmap.
  function automatic int unsigned page_limit();
    return (page_count > NUM_PAGES) ? NUM_PAGES : page_count;
  endfunction

  // Applies one request to the shadow page map and returns the response it earns.
  function automatic rsp_t apply_page_op(req_t r);
    rsp_t o;
    int unsigned lim;
    lim = page_limit();
    o.status = STAT_OK;
    o.result_index = r.page_index;
    case (r.func)
      FUNC_SET: begin
        if (r.page_index >= lim) o.status = STAT_RANGE;
        else used_pages[r.page_index] = r.mark_used;
      end
      FUNC_ALLOC: begin
        if (r.pages_wanted == 12'd0) begin
          o.status = STAT_ZERO;
        end else if (r.pages_wanted != 12'd1) begin
          o.status = STAT_MULTI;
        end else begin
          // First fit: the lowest free page below the limit wins.
          o.status = STAT_NONE;
          for (int p = 0; p < lim; p++) begin
            if (!used_pages[p]) begin
              used_pages[p] = 1'b1;
              o.status = STAT_OK;
              o.result_index = 12'(p);
              break;
            end
          end
        end
      end
      FUNC_FREE: begin
        if (r.page_index >= lim) o.status = STAT_RANGE;
        else if (!used_pages[r.page_index]) o.status = STAT_DOUBLE_FREE;
        else used_pages[r.page_index] = 1'b0;
      end
      default: ;
    endcase
    return o;
  endfunction

  function automatic req_t page_op(logic [1:0] func, int unsigned index, bit mark,
                                   int unsigned wanted);
    req_t r;
    r.func = func;
    r.page_index = 12'(index);
    r.mark_used = mark;
    r.pages_wanted = 12'(wanted);
    return r;
  endfunction

  function automatic void report_failure(string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_SHOWN) $display("%0t: %s", $time, msg);
  endfunction

  // Random request, weighted toward sequences that keep pages moving between
  // used and free near the bottom of the managed range.
  function automatic req_t random_page_op();
    req_t r;
    int unsigned lim;
    int unsigned span;
    int unsigned pick;
    lim = page_limit();
    span = (lim > 256) ? 256 : lim;
    r.func = FUNC_ALLOC;
    r.page_index = 12'($urandom);
    r.mark_used = 1'($urandom);
    r.pages_wanted = 12'd1;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      // Single-page allocation with a random echo index.
    end else if (pick < 55) begin
      // Free, usually a page that is currently in use.
      r.func = FUNC_FREE;
      if (span != 0) begin
        r.page_index = 12'($urandom_range(0, span - 1));
        for (int t = 0; t < 8 && !used_pages[r.page_index]; t++)
          r.page_index = 12'($urandom_range(0, span - 1));
      end
    end else if (pick < 75) begin
      // Mark a page, usually inside the range, sometimes at or just past its upper boundary.
      r.func = FUNC_SET;
      if (span != 0) begin
        if ($urandom_range(0, 3) == 0) r.page_index = 12'(lim - $urandom_range(0, 1));
        else r.page_index = 12'($urandom_range(0, span - 1));
      end
    end else if (pick < 85) begin
      // Allocation with a random page count, mostly zero or unsupported.
      r.pages_wanted = $urandom_range(0, 1) ? 12'($urandom) : 12'($urandom_range(0, 3));
    end else if (pick < 95) begin
      // Noise: any index, any page count.
      r.func = $urandom_range(0, 1) ? FUNC_SET : FUNC_FREE;
      r.pages_wanted = 12'($urandom);
    end else begin
      r.func = FUNC_UNUSED;
      r.pages_wanted = 12'($urandom);
    end
    return r;
  endfunction

  // Presents one request and predicts its response once it is taken.
  // Start stays high afterwards so that back-to-back requests need no gap.
  task automatic send_request(req_t r);
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    start <= 1'b1;
    request <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    awaited_results.push_back(apply_page_op(r));
  endtask

  task automatic wait_for_results();
    start <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
  endtask

  // Only called while no request is outstanding.
  task automatic write_page_count(int unsigned value);
    cfg_valid <= 1'b1;
    cfg_data <= CNT_W'(value);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    page_count = value & 32'h1FFF;
  endtask

  // Every response is matched against the oldest prediction.
  always @(posedge clk) begin
    rsp_t want;
    if (!rst && done) begin
      if (awaited_results.size() == 0) begin
        report_failure($sformatf("unexpected response: status %0d index %0d",
                                 result.status, result.result_index));
      end else begin
        want = awaited_results.pop_front();
        if (result.status !== want.status)
          report_failure($sformatf("status: expected %0d, got %0d (index %0d)",
                                   want.status, result.status, want.result_index));
        if (result.result_index !== want.result_index)
          report_failure($sformatf("result_index: expected %0d, got %0d",
                                   want.result_index, result.result_index));
      end
    end
  end

  // After reset every page is in use; walk every operation and every status but the range error.
  task automatic test_reset_state();
    send_request(page_op(FUNC_ALLOC, 12, 1'b0, 1));
    send_request(page_op(FUNC_FREE, 0, 1'b0, 0));
    send_request(page_op(FUNC_ALLOC, 4095, 1'b1, 1));
    send_request(page_op(FUNC_FREE, 4095, 1'b1, 4095));
    send_request(page_op(FUNC_FREE, 4095, 1'b0, 0));
    send_request(page_op(FUNC_SET, 4095, 1'b1, 0));
    send_request(page_op(FUNC_ALLOC, 7, 1'b0, 0));
    send_request(page_op(FUNC_ALLOC, 4095, 1'b0, 4095));
    send_request(page_op(FUNC_ALLOC, 0, 1'b0, 2));
    send_request(page_op(FUNC_UNUSED, 4095, 1'b1, 4095));
    send_request(page_op(FUNC_SET, 37, 1'b0, 0));
    send_request(page_op(FUNC_SET, 38, 1'b1, 0));
    send_request(page_op(FUNC_ALLOC, 2730, 1'b1, 1));
    wait_for_results();
  endtask

  // Empty, single-page, oversized and full page counts.
  task automatic test_count_extremes();
    write_page_count(0);
    send_request(page_op(FUNC_SET, 0, 1'b0, 0));
    send_request(page_op(FUNC_FREE, 0, 1'b1, 0));
    send_request(page_op(FUNC_ALLOC, 1365, 1'b0, 1));
    wait_for_results();
    write_page_count(1);
    send_request(page_op(FUNC_SET, 0, 1'b0, 0));
    send_request(page_op(FUNC_ALLOC, 0, 1'b0, 1));
    send_request(page_op(FUNC_FREE, 1, 1'b0, 0));
    send_request(page_op(FUNC_ALLOC, 5, 1'b0, 1));
    wait_for_results();
    write_page_count(8191);
    send_request(page_op(FUNC_FREE, 4095, 1'b0, 0));
    send_request(page_op(FUNC_ALLOC, 0, 1'b0, 1));
    wait_for_results();
    write_page_count(NUM_PAGES);
    send_request(page_op(FUNC_FREE, 4095, 1'b0, 0));
    wait_for_results();
  endtask

  // Three blocks of random requests, each under its own page count.
  task automatic test_random_traffic(int unsigned pct, int unsigned items);
    req_t r;
    int unsigned sent;
    int unsigned count;
    idle_pct = pct;
    for (int b = 0; b < 3; b++) begin
      case (b)
        0: count = $urandom_range(1, 300);
        1: count = $urandom_range(301, 8191);
        default: count = (pct == 88) ? 8191 : NUM_PAGES;
      endcase
      write_page_count(count);
      sent = 0;
      while (sent < items) begin
        r = random_page_op();
        send_request(r);
        if (r.func != FUNC_UNUSED) sent++;
      end
      wait_for_results();
    end
    idle_pct = 0;
  endtask

  initial begin
    for (int p = 0; p < NUM_PAGES; p++) used_pages[p] = 1'b1;
    page_count = CNT_RESET;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_reset_state();
    test_count_extremes();
    test_random_traffic(9, 100);
    test_random_traffic(88, 100);
    test_random_traffic(0, 100);
    wait_for_results();
    repeat (150) @(posedge clk);
    if (mismatch_count == 0 && awaited_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

### files.f
+incdir+rtl/core
rtl/core/pba_pkg.sv
rtl/core/pba_ram.sv
rtl/core/page_bitmap_allocator_core.sv
test/page_bitmap_allocator_core_tb.sv
